### design/descriptor_pool_allocator_unit_macros.svh
// Assertion macros used by the descriptor pool allocator top level.
`ifndef DESCRIPTOR_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define DESCRIPTOR_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define DPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define DPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dpa_pkg.sv
// Types, constants and codes of the descriptor pool allocator.
`timescale 1ns / 1ps
package dpa_pkg;

    localparam int COUNT_BITS       = 16;
    localparam int MAX_HEAPS_DEF    = 16;
    localparam int FREE_DEPTH_DEF   = 64;
    localparam logic [15:0] DEFAULT_PER_HEAP = 16'd1024;
    localparam logic [8:0]  DEFAULT_DESC_SIZE = 9'd32;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_RESET   = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_NO_ROOM  = 3'd2;
    localparam logic [2:0] ST_LIST_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_HEAP = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_MAX_HEAP  = 2'd1;
    localparam logic [1:0] REG_DESC_SIZE = 2'd2;
    localparam logic [1:0] REG_SHADER    = 2'd3;

    typedef struct packed {
        logic [3:0]            heap;
        logic [COUNT_BITS-1:0] offset;
        logic [COUNT_BITS-1:0] count;
    } t_run;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COUNT_BITS-1:0] cnt;
        logic [3:0]            rheap;
        logic [COUNT_BITS-1:0] roff;
    } t_item;

    typedef struct packed {
        logic                  enabled;
        logic [COUNT_BITS-1:0] max_per_heap;
        logic [8:0]            desc_size;
        logic                  shader_visible;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  heap;
        logic [15:0] slot_offset;
        logic [23:0] byte_offset;
        logic        gpu_valid;
    } t_result;

endpackage

### design/dpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module dpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/dpa_engine.sv
// Command sequencer of the allocator: free list scan, run removal, heap scan, usage sweep.
`timescale 1ns / 1ps
module dpa_engine
    import dpa_pkg::*;
#(
    parameter int MAX_HEAPS  = MAX_HEAPS_DEF,
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_idle,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int FA  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FCW = $clog2(FREE_DEPTH + 1);
    localparam int HA  = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
    localparam int HCW = $clog2(MAX_HEAPS + 1);
    localparam int CW  = COUNT_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FSCAN = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_HSCAN = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]     r_state, n_state;
    t_item          r_item, n_item;
    logic [FCW-1:0] r_fcount, n_fcount;
    logic [HCW-1:0] r_htotal, n_htotal;
    logic [FCW-1:0] r_fi, n_fi;
    logic [HCW-1:0] r_hi, n_hi;
    logic           r_rv, n_rv;
    logic [FA-1:0]  r_fa, n_fa;
    logic [HA-1:0]  r_ha, n_ha;
    logic [2:0]     r_status, n_status;
    logic [3:0]     r_heap, n_heap;
    logic [CW-1:0]  r_off, n_off;
    logic [23:0]    r_byte, n_byte;

    logic           w_fwe, w_fre;
    logic [FA-1:0]  w_fwaddr, w_fraddr;
    t_run           w_fwdata, w_frdata;
    logic           w_uwe, w_cwe, w_hre;
    logic [HA-1:0]  w_uwaddr, w_hraddr;
    logic [CW-1:0]  w_uwdata, w_cwdata, w_urdata, w_crdata;
    logic [24:0]    w_prod;
    logic [CW:0]    w_hsum;
    logic           w_fhit, w_hhit;

    dpa_ram #(.WIDTH($bits(t_run)), .DEPTH(FREE_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_fwaddr),
        .i_wdata (w_fwdata),
        .i_re    (w_fre),
        .i_raddr (w_fraddr),
        .o_rdata (w_frdata)
    );

    dpa_ram #(.WIDTH(CW), .DEPTH(MAX_HEAPS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_uwe),
        .i_waddr (w_uwaddr),
        .i_wdata (w_uwdata),
        .i_re    (w_hre),
        .i_raddr (w_hraddr),
        .o_rdata (w_urdata)
    );

    dpa_ram #(.WIDTH(CW), .DEPTH(MAX_HEAPS)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_uwaddr),
        .i_wdata (w_cwdata),
        .i_re    (w_hre),
        .i_raddr (w_hraddr),
        .o_rdata (w_crdata)
    );

    assign w_prod = {9'b0, r_off} * {16'b0, i_cfg.desc_size};
    assign w_hsum = {1'b0, w_urdata} + {1'b0, r_item.cnt};
    assign w_fhit = r_rv && (w_frdata.count >= r_item.cnt);
    assign w_hhit = r_rv && (w_hsum <= {1'b0, w_crdata});

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_fcount = r_fcount;
        n_htotal = r_htotal;
        n_fi     = r_fi;
        n_hi     = r_hi;
        n_rv     = r_rv;
        n_fa     = r_fa;
        n_ha     = r_ha;
        n_status = r_status;
        n_heap   = r_heap;
        n_off    = r_off;
        n_byte   = r_byte;
        w_fwe    = 1'b0;
        w_fwaddr = r_fa;
        w_fwdata = w_frdata;
        w_fre    = 1'b0;
        w_fraddr = r_fi[FA-1:0];
        w_uwe    = 1'b0;
        w_cwe    = 1'b0;
        w_uwaddr = r_ha;
        w_uwdata = '0;
        w_cwdata = '0;
        w_hre    = 1'b0;
        w_hraddr = r_hi[HA-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item   = i_item;
                    n_fi     = '0;
                    n_hi     = '0;
                    n_rv     = 1'b0;
                    n_status = ST_DONE;
                    n_state  = S_MUL;
                    case (i_item.cmd)
                        CMD_ALLOC: begin
                            if (!i_cfg.enabled || (i_item.cnt == '0)) begin
                                n_status = ST_REJECTED;
                            end else begin
                                n_state = S_FSCAN;
                            end
                        end
                        CMD_RELEASE: begin
                            if (!i_cfg.enabled) begin
                                n_status = ST_REJECTED;
                            end else if ((HCW + 4)'(i_item.rheap) >= (HCW + 4)'(r_htotal)) begin
                                n_status = ST_BAD_HEAP;
                            end else if (r_fcount >= FCW'(FREE_DEPTH)) begin
                                n_status = ST_LIST_FULL;
                            end else begin
                                w_fwe    = 1'b1;
                                w_fwaddr = r_fcount[FA-1:0];
                                w_fwdata = '{heap: i_item.rheap, offset: i_item.roff,
                                             count: i_item.cnt};
                                n_fcount = r_fcount + 1'b1;
                            end
                        end
                        CMD_RESET: begin
                            n_fcount = '0;
                            n_state  = S_ZERO;
                        end
                        default: begin
                            n_fcount = '0;
                            n_htotal = '0;
                        end
                    endcase
                end
            end
            S_FSCAN: begin
                if (w_fhit) begin
                    n_status = ST_GRANTED;
                    n_heap   = w_frdata.heap;
                    n_off    = w_frdata.offset;
                    if (w_frdata.count > r_item.cnt) begin
                        w_fwe    = 1'b1;
                        w_fwaddr = r_fa;
                        w_fwdata = '{heap: w_frdata.heap,
                                     offset: CW'(w_frdata.offset + r_item.cnt),
                                     count: CW'(w_frdata.count - r_item.cnt)};
                        n_state  = S_MUL;
                    end else begin
                        n_fi    = FCW'(r_fa) + 1'b1;
                        n_rv    = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else if (r_fi < r_fcount) begin
                    w_fre = 1'b1;
                    n_fa  = r_fi[FA-1:0];
                    n_rv  = 1'b1;
                    n_fi  = r_fi + 1'b1;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_state = S_HSCAN;
                    end
                end
            end
            S_SHIFT: begin
                if (r_rv) begin
                    w_fwe    = 1'b1;
                    w_fwaddr = r_fa - 1'b1;
                    w_fwdata = w_frdata;
                end
                if (r_fi < r_fcount) begin
                    w_fre = 1'b1;
                    n_fa  = r_fi[FA-1:0];
                    n_rv  = 1'b1;
                    n_fi  = r_fi + 1'b1;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_fcount = r_fcount - 1'b1;
                        n_state  = S_MUL;
                    end
                end
            end
            S_HSCAN: begin
                if (w_hhit) begin
                    w_uwe    = 1'b1;
                    w_uwaddr = r_ha;
                    w_uwdata = w_hsum[CW-1:0];
                    n_status = ST_GRANTED;
                    n_heap   = 4'(r_ha);
                    n_off    = w_urdata;
                    n_state  = S_MUL;
                end else if (r_hi < r_htotal) begin
                    w_hre = 1'b1;
                    n_ha  = r_hi[HA-1:0];
                    n_rv  = 1'b1;
                    n_hi  = r_hi + 1'b1;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_state = S_MUL;
                        if (r_htotal < HCW'(MAX_HEAPS)) begin
                            w_uwe    = 1'b1;
                            w_cwe    = 1'b1;
                            w_uwaddr = r_htotal[HA-1:0];
                            w_uwdata = r_item.cnt;
                            w_cwdata = (r_item.cnt > i_cfg.max_per_heap) ?
                                       r_item.cnt : i_cfg.max_per_heap;
                            n_status = ST_GRANTED;
                            n_heap   = 4'(r_htotal);
                            n_off    = '0;
                            n_htotal = r_htotal + 1'b1;
                        end else begin
                            n_status = ST_NO_ROOM;
                        end
                    end
                end
            end
            S_ZERO: begin
                if (r_hi < r_htotal) begin
                    w_uwe    = 1'b1;
                    w_uwaddr = r_hi[HA-1:0];
                    w_uwdata = '0;
                    n_hi     = r_hi + 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_status == ST_GRANTED) begin
                    n_byte = w_prod[23:0];
                end else begin
                    n_byte = '0;
                    n_heap = '0;
                    n_off  = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcount <= '0;
            r_htotal <= '0;
            r_rv     <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_fcount <= n_fcount;
            r_htotal <= n_htotal;
            r_rv     <= n_rv;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_fi   <= n_fi;
        r_hi   <= n_hi;
        r_fa   <= n_fa;
        r_ha   <= n_ha;
        r_heap <= n_heap;
        r_off  <= n_off;
        r_byte <= n_byte;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, heap: r_heap, slot_offset: r_off,
                           byte_offset: r_byte,
                           gpu_valid: (r_status == ST_GRANTED) && i_cfg.shader_visible};

endmodule

### design/descriptor_pool_allocator_unit.sv
// Top level of the descriptor pool allocator: stream ports, registers, result register.
//
// Channel  | Ports            | Payload
// ---------+------------------+-----------------------------------------------
// command  | i_s_axis_*       | tuser: cmd; tdata: slot_count, heap, offset
// result   | o_m_axis_*       | tuser: status; tdata: heap, slot, byte, gpu
// config   | i_cfg_*          | index 0..3, data up to 16 bits, write only
//
// Allocate scans the free runs, moves the runs behind a hit up on an exact fit and
// scans the heaps when no run fits; each memory is read at most once per cycle.
// The reset usage command zeroes the used count of each allocated heap in turn.
// Reset clears the state and the run and heap counters; the memories are not swept.
// A result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`include "descriptor_pool_allocator_unit_macros.svh"
module descriptor_pool_allocator_unit
    import dpa_pkg::*;
#(
    parameter int MAX_HEAPS  = MAX_HEAPS_DEF,
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // slot_count [15:0], release_heap [19:16], release_offset [35:20], zero [39:36]
    input  logic [39:0] i_s_axis_tdata,
    // cmd [1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // heap_number [3:0], slot_offset [19:4], byte_offset [43:20],
    // gpu_handle_valid [44], zero [47:45]
    output logic [47:0] o_m_axis_tdata,
    // status [2:0]
    output logic [2:0]  o_m_axis_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;
    t_result r_out;
    logic    r_out_valid;
    logic    w_idle, w_res_valid, w_res_ready, w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{enabled: 1'b0, max_per_heap: DEFAULT_PER_HEAP,
                       desc_size: DEFAULT_DESC_SIZE, shader_visible: 1'b0};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ENABLED:   r_cfg.enabled        <= i_cfg_data[0];
                REG_MAX_HEAP:  r_cfg.max_per_heap   <= i_cfg_data;
                REG_DESC_SIZE: r_cfg.desc_size      <= i_cfg_data[8:0];
                REG_SHADER:    r_cfg.shader_visible <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_item = '{cmd: i_s_axis_tuser, cnt: i_s_axis_tdata[15:0],
                      rheap: i_s_axis_tdata[19:16], roff: i_s_axis_tdata[35:20]};
    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign w_res_ready     = !r_out_valid || i_m_axis_tready;

    dpa_engine #(.MAX_HEAPS(MAX_HEAPS), .FREE_DEPTH(FREE_DEPTH)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .i_cfg       (r_cfg),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {3'b000, r_out.gpu_valid, r_out.byte_offset,
                              r_out.slot_offset, r_out.heap};

    `DPA_ASSERT_NOW(a_busy_no_accept, w_res_valid, !o_s_axis_tready, "result pending while ready")
    `DPA_ASSERT_NOW(a_zero_fields, w_res_valid && (w_res.status != ST_GRANTED),
        (w_res.heap == 4'd0) && (w_res.slot_offset == 16'd0) && (w_res.byte_offset == 24'd0),
        "non-grant result carries payload")
    `DPA_ASSERT_NOW(a_gpu_valid, w_res_valid && w_res.gpu_valid,
        (w_res.status == ST_GRANTED) && r_cfg.shader_visible, "gpu handle flag without grant")
    `DPA_ASSERT_NEXT(a_start_leaves_idle, w_start, !o_s_axis_tready, "command not taken up")

endmodule
